@@ rtl/ckpq_pkg.sv @@
// ckpq_pkg: shared types and codes for the composite-key priority queue.
// Used by ckpq_beats and composite_key_priority_queue; depends on nothing.

package ckpq_pkg;

    // Operation codes carried in a request transaction
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOAD   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Completion status carried in a response transaction
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam int ID_W  = 16;
    localparam int AGE_W = 7;
    localparam int PRI_W = 8;
    localparam int OCC_W = 7;

    localparam logic [ID_W-1:0] ID_MAX   = '1;
    localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

    typedef struct packed {
        op_t              operation;
        logic [ID_W-1:0]  given_id;
        logic [AGE_W-1:0] age;
        logic [PRI_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  out_id;
        logic [AGE_W-1:0] out_age;
        logic [PRI_W-1:0] out_priority;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    // One stored entry
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
        logic [PRI_W-1:0] pri;
    } entry_t;

endpackage

@@ rtl/ckpq_beats.sv @@
// ckpq_beats: composite-key comparator shared by the scan sequencer.
// Depends on ckpq_pkg (entry_t).

module ckpq_beats
(
    input  ckpq_pkg::entry_t cand,
    input  ckpq_pkg::entry_t best,
    output logic             cand_wins
);

    // Lower priority first, then higher age, then lower id; a full tie keeps best
    always_comb
    begin
        if (cand.pri != best.pri)
            cand_wins = (cand.pri < best.pri);
        else if (cand.age != best.age)
            cand_wins = (cand.age > best.age);
        else
            cand_wins = (cand.id < best.id);
    end

endmodule

@@ rtl/composite_key_priority_queue.sv @@
// composite_key_priority_queue: priority queue with linear-scan extract-min.
// Depends on ckpq_pkg and ckpq_beats.
//
//   channel | valid     | stall     | payload          | direction
//   --------+-----------+-----------+------------------+----------
//   request | req_valid | req_stall | req (req_t)      | in
//   reply   | rsp_valid | rsp_stall | rsp (rsp_t)      | out
//
// Insert, load and clear pass through S_EXEC to S_POST, which loads the reply register
// once it is free. Remove makes two passes over the N stored entries: a pass of the
// entry memory finds the best, a pass from it copies each later entry down one slot,
// with one read and one write per cycle. Reset empties the queue, sets the next id
// to 1 and leaves entry memory as is. A request is taken only while idle; a reply
// held by rsp_stall does not block it, but the next reply waits for it.

module composite_key_priority_queue
#(
    parameter int CAPACITY = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  ckpq_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ckpq_pkg::rsp_t   rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_POST
    } state_t;

    state_t                          state_reg;
    ckpq_pkg::req_t                  req_reg;
    ckpq_pkg::rsp_t                  result_reg;
    ckpq_pkg::rsp_t                  rsp_reg;
    logic                            rsp_valid_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [ckpq_pkg::ID_W-1:0]       next_id_reg;
    logic [CNT_W-1:0]                rd_idx_reg;
    logic                            pend_reg;
    logic [CNT_W-1:0]                pend_idx_reg;
    ckpq_pkg::entry_t                best_reg;
    logic [IDX_W-1:0]                best_idx_reg;

    // Entry memory: one write and one registered read per cycle
    ckpq_pkg::entry_t                mem [CAPACITY];
    ckpq_pkg::entry_t                rd_data_reg;
    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    ckpq_pkg::entry_t                mem_wdata;
    logic [IDX_W-1:0]                mem_raddr;

    logic                            req_fire;
    logic                            rsp_free;
    logic                            issue;
    logic                            cand_wins;
    logic                            take;
    ckpq_pkg::entry_t                best_upd;
    logic [IDX_W-1:0]                best_idx_upd;
    logic [ckpq_pkg::ID_W-1:0]       new_id;
    ckpq_pkg::entry_t                new_entry;

    // Reply word for a finished operation
    function automatic ckpq_pkg::rsp_t pack_rsp(ckpq_pkg::status_t st, ckpq_pkg::entry_t e,
                                                logic [CNT_W-1:0] occ);
        ckpq_pkg::rsp_t r;
        r.status       = st;
        r.out_id       = e.id;
        r.out_age      = e.age;
        r.out_priority = e.pri;
        r.occupancy    = ckpq_pkg::OCC_W'(occ);
        return r;
    endfunction

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign issue     = (rd_idx_reg < count_reg);
    assign mem_raddr = rd_idx_reg[IDX_W-1:0];

    // Entry built by insert or load
    assign new_id = (req_reg.operation == ckpq_pkg::OP_INSERT) ? next_id_reg
                                                               : req_reg.given_id;
    assign new_entry = '{id: new_id, age: req_reg.age, pri: req_reg.priority_req};

    // Shared comparator: the entry just read against the best so far
    ckpq_beats u_beats
    (
        .cand      (rd_data_reg),
        .best      (best_reg),
        .cand_wins (cand_wins)
    );

    assign take         = (pend_idx_reg == '0) || cand_wins;
    assign best_upd     = take ? rd_data_reg : best_reg;
    assign best_idx_upd = take ? pend_idx_reg[IDX_W-1:0] : best_idx_reg;

    // Memory write select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = new_entry;
        if (state_reg == S_EXEC)
        begin
            mem_we = ((req_reg.operation == ckpq_pkg::OP_INSERT) ||
                      (req_reg.operation == ckpq_pkg::OP_LOAD)) &&
                     (count_reg != CNT_FULL);
        end
        else if (state_reg == S_SHIFT)
        begin
            mem_we    = pend_reg;
            mem_waddr = IDX_W'(pend_idx_reg - CNT_ONE);
            mem_wdata = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // Sequencer, counters and reply register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            result_reg    <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            next_id_reg   <= ckpq_pkg::ID_FIRST;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            best_reg      <= '0;
            best_idx_reg  <= '0;
        end
        else
        begin
            // Reply valid: set when a result is handed over, cleared when taken
            if ((state_reg == S_POST) && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        req_reg   <= req;
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    unique case (req_reg.operation)
                        ckpq_pkg::OP_INSERT,
                        ckpq_pkg::OP_LOAD:
                        begin
                            state_reg <= S_POST;
                            if (count_reg == CNT_FULL)
                            begin
                                result_reg <= pack_rsp(ckpq_pkg::ST_FULL, '0, count_reg);
                            end
                            else
                            begin
                                count_reg <= count_reg + CNT_ONE;
                                if (new_id >= next_id_reg)
                                    next_id_reg <= (new_id == ckpq_pkg::ID_MAX) ?
                                                   ckpq_pkg::ID_MAX :
                                                   new_id + ckpq_pkg::ID_W'(1);
                                result_reg <= pack_rsp(ckpq_pkg::ST_OK, new_entry,
                                                       count_reg + CNT_ONE);
                            end
                        end
                        ckpq_pkg::OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                result_reg <= pack_rsp(ckpq_pkg::ST_EMPTY, '0, '0);
                                state_reg  <= S_POST;
                            end
                            else
                            begin
                                rd_idx_reg <= '0;
                                pend_reg   <= 1'b0;
                                state_reg  <= S_SCAN;
                            end
                        end
                        ckpq_pkg::OP_CLEAR:
                        begin
                            count_reg  <= '0;
                            result_reg <= pack_rsp(ckpq_pkg::ST_OK, '0, '0);
                            state_reg  <= S_POST;
                        end
                        default:
                        begin
                            result_reg <= '0;
                            state_reg  <= S_POST;
                        end
                    endcase
                end

                // Pass 1: read every entry, keep the best
                S_SCAN:
                begin
                    pend_idx_reg <= rd_idx_reg;
                    if (pend_reg)
                    begin
                        best_reg     <= best_upd;
                        best_idx_reg <= best_idx_upd;
                    end
                    if (pend_reg && (pend_idx_reg == count_reg - CNT_ONE))
                    begin
                        rd_idx_reg <= CNT_W'(best_idx_upd) + CNT_ONE;
                        pend_reg   <= 1'b0;
                        state_reg  <= S_SHIFT;
                    end
                    else
                    begin
                        pend_reg <= issue;
                        if (issue)
                            rd_idx_reg <= rd_idx_reg + CNT_ONE;
                    end
                end

                // Pass 2: copy each later entry down one slot
                S_SHIFT:
                begin
                    pend_reg     <= issue;
                    pend_idx_reg <= rd_idx_reg;
                    if (issue)
                        rd_idx_reg <= rd_idx_reg + CNT_ONE;
                    if (!issue && !pend_reg)
                    begin
                        count_reg  <= count_reg - CNT_ONE;
                        result_reg <= pack_rsp(ckpq_pkg::ST_OK, best_reg,
                                               count_reg - CNT_ONE);
                        state_reg  <= S_POST;
                    end
                end

                // Hand the result to the reply register once it is free
                S_POST:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg   <= result_reg;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
